[sv/d2i_pkg.sv]
// ----------------------------------------------------------------------------
// d2i_pkg
// shared constants and types for the double to int64 converter
// ----------------------------------------------------------------------------
package d2i_pkg;

    localparam int RESULT_WIDTH = 64;
    localparam int MAG_W        = RESULT_WIDTH + 1;

    localparam logic [1:0] RM_NEAREST = 2'd0;
    localparam logic [1:0] RM_DOWN    = 2'd1;
    localparam logic [1:0] RM_UP      = 2'd2;
    localparam logic [1:0] RM_ZERO    = 2'd3;

    localparam logic [10:0] EXP_ALL1  = 11'h7FF;
    localparam logic [10:0] EXP_INT   = 11'd1075;

    // stage 1 to stage 2: decoded fields
    typedef struct packed {
        logic        neg;
        logic        inv;
        logic        big;
        logic [3:0]  lsh;
        logic [5:0]  rsh;
        logic        tiny;
        logic [52:0] mant;
        logic [1:0]  mode;
    } dec_t;

    // stage 2 to stage 3: integer part and rounding decision
    typedef struct packed {
        logic        neg;
        logic        inv;
        logic [63:0] ip;
        logic        up;
    } rnd_t;

endpackage

[sv/d2i_round.sv]
// ----------------------------------------------------------------------------
// d2i_round
// alignment shift and rounding decision for one decoded beat
// ----------------------------------------------------------------------------
module d2i_round (
    input  d2i_pkg::dec_t d,
    output d2i_pkg::rnd_t r
);
    import d2i_pkg::*;

    logic [116:0] wide;
    logic [63:0]  ip;
    logic [52:0]  rem;
    logic [52:0]  half;
    logic         nz;
    logic         above;
    logic         tie;
    logic         up;

    always_comb
    begin
        wide  = {64'd0, d.mant} << d.lsh;
        half  = 53'd0;
        rem   = 53'd0;
        ip    = 64'd0;
        if (d.big)
        begin
            ip = wide[63:0];
        end
        else if (d.tiny)
        begin
            ip = 64'd0;
        end
        else
        begin
            ip   = {11'd0, d.mant >> d.rsh};
            rem  = d.mant & ((53'd1 << d.rsh) - 53'd1);
            half = 53'd1 << (d.rsh - 6'd1);
        end
        nz    = d.tiny ? (d.mant != 53'd0) : (rem != 53'd0);
        above = !d.tiny && (rem > half);
        tie   = !d.tiny && (rem == half);
        case (d.mode)
            RM_NEAREST: up = above || (tie && ip[0]);
            RM_DOWN:    up = d.neg && nz;
            RM_UP:      up = !d.neg && nz;
            default:    up = 1'b0;
        endcase
        r.neg = d.neg;
        r.inv = d.inv || (d.big && (wide[116:64] != 53'd0));
        r.ip  = ip;
        r.up  = up && !d.big;
    end

endmodule

[sv/double_to_int64_round_convert.sv]
// ----------------------------------------------------------------------------
// double_to_int64_round_convert
// ieee-754 double to signed integer conversion with a selectable rounding mode
// ----------------------------------------------------------------------------
//  beat       | signals                              | dir
//  input      | in_valid, in_stall, value_bits       | in
//  result     | out_valid, out_stall, int_result, invalid_flag | out
//  config     | cfg_we, cfg_data (round_mode)        | in
//
// four register stages: decode, align/round, increment/range, output
// one beat per cycle while no result beat waits under out_stall
// reset clears valid bits and sets round_mode to nearest-even
// a stall on a valid output beat freezes the whole pipe; in_stall follows it
// ----------------------------------------------------------------------------
module double_to_int64_round_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [63:0] int_result,
    output logic        invalid_flag
);
    import d2i_pkg::*;

    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (RESULT_WIDTH - 1);

    logic [1:0]  mode_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    dec_t        s1_reg, s1_next;
    rnd_t        s2_reg, s2_next;
    logic        s3_neg_reg, s3_inv_reg;
    logic [MAG_W-1:0] s3_mag_reg;
    logic [63:0] res_reg, res_next;
    logic        inv_reg, inv_next;
    logic        adv;

    logic        neg;
    logic [10:0] bexp;
    logic [52:0] mant;
    logic [10:0] sh_r;

    assign adv      = !(v4_reg && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        neg  = value_bits[63];
        bexp = value_bits[62:52];
        mant = {bexp != 11'd0, value_bits[51:0]};
        sh_r = (bexp == 11'd0) ? 11'd1074 : (EXP_INT - bexp);
        s1_next.neg  = neg;
        s1_next.inv  = (bexp == EXP_ALL1);
        s1_next.big  = (bexp >= EXP_INT);
        s1_next.lsh  = (bexp >= EXP_INT) && (bexp - EXP_INT <= 11'd11)
                       ? 4'(bexp - EXP_INT) : 4'd0;
        s1_next.inv  = s1_next.inv || ((bexp >= EXP_INT) && (bexp != EXP_ALL1)
                       && (bexp - EXP_INT > 11'd11));
        s1_next.tiny = (bexp < EXP_INT) && (sh_r >= 11'd54);
        s1_next.rsh  = 6'(sh_r);
        s1_next.mant = mant;
        s1_next.mode = mode_reg;
    end

    d2i_round u_round (
        .d (s1_reg),
        .r (s2_next)
    );

    always_comb
    begin
        inv_next = s3_inv_reg || (s3_neg_reg ? (s3_mag_reg > NEG_LIM)
                                             : (s3_mag_reg > NEG_LIM - MAG_W'(1)));
        if (inv_next)
            res_next = 64'(signed'(-NEG_LIM));
        else if (s3_neg_reg)
            res_next = 64'(signed'(-s3_mag_reg));
        else
            res_next = 64'(s3_mag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RM_NEAREST;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (adv)
            begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_neg_reg <= s2_reg.neg;
            s3_inv_reg <= s2_reg.inv;
            s3_mag_reg <= MAG_W'(s2_reg.ip) + MAG_W'(s2_reg.up);
            res_reg    <= res_next;
            inv_reg    <= inv_next;
        end
    end

    assign out_valid    = v4_reg;
    assign int_result   = res_reg;
    assign invalid_flag = inv_reg;

    // a stalled result beat stays valid and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(int_result))
        else $error("result changed under stall");

    // invalid results always carry the most negative integer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid_flag |-> int_result == 64'h8000000000000000)
        else $error("invalid result not saturated");

    // input is stalled only while an output beat waits
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");

endmodule

[dv/double_to_int64_round_convert_tb.sv]
// ----------------------------------------------------------------------------
// double_to_int64_round_convert_tb
// drives raw double patterns through the converter under every rounding mode
// and checks each rounded integer and invalid flag against a local predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_to_int64_round_convert_tb;
    import d2i_pkg::*;

    typedef struct {
        logic [63:0] int_result;
        logic        invalid_flag;
    } conv_result_t;

    class conv_scoreboard;
        logic [1:0]   mode;
        conv_result_t pending[$];
        int           errors;

        function new();
            mode = RM_NEAREST;
            errors = 0;
        endfunction

        // rounds one double to a signed RESULT_WIDTH-bit integer
        function conv_result_t convert(logic [63:0] bits);
            conv_result_t r;
            logic        neg;
            logic [10:0] bexp;
            logic [63:0] mant, mag, ip, rem, half, lim;
            logic        nonzero, above, tie, up, inv;
            int          sh;
            neg = bits[63];
            bexp = bits[62:52];
            mant = {11'd0, bexp != 0, bits[51:0]};
            mag = 0;
            inv = 0;
            up = 0;
            lim = 64'd1 << (RESULT_WIDTH - 1);
            if (bexp == EXP_ALL1)
                inv = 1;
            else if (bexp >= EXP_INT)
            begin
                sh = bexp - EXP_INT;
                if (sh > 11)
                    inv = 1;
                else
                    mag = mant << sh;
            end
            else
            begin
                sh = (bexp != 0) ? (EXP_INT - bexp) : 1074;
                if (sh >= 54)
                begin
                    ip = 0;
                    nonzero = mant != 0;
                    above = 0;
                    tie = 0;
                end
                else
                begin
                    half = 64'd1 << (sh - 1);
                    ip = mant >> sh;
                    rem = mant & ((64'd1 << sh) - 1);
                    nonzero = rem != 0;
                    above = rem > half;
                    tie = rem == half;
                end
                case (mode)
                    RM_NEAREST: up = above || (tie && ip[0]);
                    RM_DOWN:    up = neg && nonzero;
                    RM_UP:      up = !neg && nonzero;
                    default:    up = 0;
                endcase
                mag = ip + up;
            end
            if (!inv)
                inv = neg ? (mag > lim) : (mag > lim - 1);
            r.invalid_flag = inv;
            r.int_result = inv ? (64'd0 - lim) : (neg ? 64'd0 - mag : mag);
            return r;
        endfunction

        function void note_input(logic [63:0] bits);
            pending.push_back(convert(bits));
        endfunction

        function void check_result(logic [63:0] res, logic flag);
            conv_result_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected: %h %b", res, flag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (res !== e.int_result)
            begin
                $error("int_result expected %h actual %h", e.int_result, res);
                errors++;
            end
            if (flag !== e.invalid_flag)
            begin
                $error("invalid_flag expected %b actual %b", e.invalid_flag, flag);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] value_bits;
    logic        out_valid;
    logic        out_stall;
    logic signed [63:0] int_result;
    logic        invalid_flag;

    conv_scoreboard sb;
    bit             idle_on;
    bit             done;
    int             quiet_cycles;

    localparam int WATCHDOG = 2000;

    double_to_int64_round_convert uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value_bits   (value_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .int_result   (int_result),
        .invalid_flag (invalid_flag)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // sample at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(value_bits);
            if (out_valid && !out_stall)
                sb.check_result(int_result, invalid_flag);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 13);
                out_stall = 1;
                repeat (n) @(negedge clk);
                out_stall = 0;
            end
        end
    end

    task automatic send_beat(logic [63:0] bits);
        int n;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 13);
            in_valid = 0;
            repeat (n) @(negedge clk);
        end
        in_valid = 1;
        value_bits = bits;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        cfg_we = 1;
        cfg_data = m;
        @(negedge clk);
        cfg_we = 0;
        sb.mode = m;
    endtask

    // random double patterns, mostly near the interesting exponent band, some with nan/inf or zero exponents
    function automatic logic [63:0] rand_double();
        logic [63:0] b;
        int k;
        b = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        if (k < 5)
            b[62:52] = 11'($urandom_range(1015, 1090));
        else if (k < 7)
            b[62:52] = 11'($urandom_range(1020, 1034));
        else if (k == 7)
            b[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
        else if (k == 8)
            b[51:0] = $urandom_range(0, 1) ? 52'd0 : 52'h8000000000000;
        return b;
    endfunction

    initial
    begin
        logic [63:0] directed[$];
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_data = 0;
        in_valid = 0;
        value_bits = 0;
        idle_on = 1;
        quiet_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        directed = '{64'h0, 64'h8000000000000000, 64'h0000000000000001,
                     64'h800FFFFFFFFFFFFF, 64'h3FE0000000000000, 64'hBFE0000000000000,
                     64'h3FF8000000000000, 64'h4004000000000000, 64'hC004000000000000,
                     64'h3FEFFFFFFFFFFFFF, 64'h4330000000000001, 64'h433FFFFFFFFFFFFF,
                     64'h43DFFFFFFFFFFFFF, 64'h43E0000000000000, 64'hC3E0000000000000,
                     64'hC3E0000000000001, 64'h7FF0000000000000, 64'hFFF0000000000000,
                     64'h7FF8000000000001, 64'hFFFFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF,
                     64'hBFF0000000000000, 64'h432FFFFFFFFFFFFF};
        // reset mode is nearest-even, then each mode in turn
        for (int m = 0; m < 4; m++)
        begin
            if (m != 0)
                set_mode(m[1:0]);
            foreach (directed[i])
                send_beat(directed[i]);
        end

        for (int i = 0; i < 760; i++)
        begin
            if (i % 120 == 119)
                set_mode(2'($urandom_range(0, 3)));
            if (i == 620)
                idle_on = 0;
            send_beat(rand_double());
        end
        set_mode(RM_ZERO);
        send_beat(64'hC3E0000000000000);
        drain();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[double_to_int64_round_convert.f]
sv/d2i_pkg.sv
sv/d2i_round.sv
sv/double_to_int64_round_convert.sv
dv/double_to_int64_round_convert_tb.sv
